FILE: design/tws_pkg.sv
`timescale 1ns / 1ps

package tws_pkg;

    localparam logic [1:0] OP_CLOCK = 2'd0;
    localparam logic [1:0] OP_IO    = 2'd1;
    localparam logic [1:0] OP_POP   = 2'd2;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    localparam int BYTE_BITS = 8;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = 2;

    typedef struct packed {
        logic       vld;
        logic [1:0] kind;
        logic [7:0] data;
    } t_event_req;

    // result as it leaves the block, LSB first: hit, kind, data
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       hit;
    } t_result;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic room;
        logic full;
    } t_ob_status;

endpackage

FILE: design/tws_decode.sv
`timescale 1ns / 1ps

module tws_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic [1:0]          i_op,
    input  logic                i_clk_lvl,
    input  logic                i_io_lvl,
    output tws_pkg::t_event_req o_push
);
    import tws_pkg::*;

    logic       r_in_frame, n_in_frame;
    logic       r_start_pend, n_start_pend;
    logic [3:0] r_bit_cnt, n_bit_cnt;
    logic [7:0] r_shift, n_shift;
    logic       r_prev_io, n_prev_io;
    logic [3:0] bit_inc;
    logic [7:0] shift_upd;

    assign bit_inc   = r_bit_cnt + 4'd1;
    assign shift_upd = r_shift | (8'(i_io_lvl) << r_bit_cnt[2:0]);

    always_comb begin
        n_in_frame   = r_in_frame;
        n_start_pend = r_start_pend;
        n_bit_cnt    = r_bit_cnt;
        n_shift      = r_shift;
        n_prev_io    = r_prev_io;
        o_push       = '0;
        if (i_acc) begin
            priority if (i_op == OP_CLOCK) begin
                if (r_start_pend) begin
                    n_start_pend = 1'b0;
                    n_in_frame   = 1'b1;
                    o_push.vld   = 1'b1;
                    o_push.kind  = KIND_START;
                end
                if (r_in_frame || r_start_pend) begin
                    n_shift   = shift_upd;
                    n_bit_cnt = bit_inc;
                    if (bit_inc >= 4'(BYTE_BITS)) begin
                        o_push.vld  = 1'b1;
                        o_push.kind = KIND_DATA;
                        o_push.data = shift_upd;
                        n_bit_cnt   = '0;
                        n_shift     = '0;
                    end
                end
            end else if (i_op == OP_IO) begin
                if (i_clk_lvl) begin
                    if (r_prev_io && !i_io_lvl) begin
                        if (!r_in_frame && !r_start_pend) begin
                            n_bit_cnt    = '0;
                            n_shift      = '0;
                            n_start_pend = 1'b1;
                        end
                    end else if (!r_prev_io && i_io_lvl) begin
                        if (r_in_frame) begin
                            n_in_frame  = 1'b0;
                            n_bit_cnt   = '0;
                            n_shift     = '0;
                            o_push.vld  = 1'b1;
                            o_push.kind = KIND_STOP;
                        end else begin
                            n_start_pend = 1'b0;
                        end
                    end
                end
                n_prev_io = i_io_lvl;
            end else begin
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_start_pend <= 1'b0;
            r_bit_cnt    <= '0;
            r_shift      <= '0;
            r_prev_io    <= 1'b1;
        end else begin
            r_in_frame   <= n_in_frame;
            r_start_pend <= n_start_pend;
            r_bit_cnt    <= n_bit_cnt;
            r_shift      <= n_shift;
            r_prev_io    <= n_prev_io;
        end
    end

endmodule

FILE: design/tws_queue.sv
`timescale 1ns / 1ps

module tws_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tws_pkg::t_event_req i_push,
    input  logic                i_pop,
    output logic                o_res_vld,
    output tws_pkg::t_result    o_res,
    output tws_pkg::t_q_status  o_stat
);
    import tws_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

    logic [9:0]    r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] wp_next, rp_next;
    logic          wr_en, rd_en;
    logic          r_rd_vld;
    logic          r_rd_hit;
    logic [9:0]    r_rd_word;

    assign wp_next      = (r_wp == LAST) ? '0 : r_wp + 1'b1;
    assign rp_next      = (r_rp == LAST) ? '0 : r_rp + 1'b1;
    assign o_stat.empty = (r_rp == r_wp);
    assign o_stat.full  = (wp_next == r_rp);
    assign wr_en        = i_push.vld && !o_stat.full;
    assign rd_en        = i_pop && !o_stat.empty;

    always_comb begin
        n_wp = wr_en ? wp_next : r_wp;
        n_rp = rd_en ? rp_next : r_rp;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= {i_push.kind, i_push.data};
        end
        if (rd_en) begin
            r_rd_word <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_rd_vld <= 1'b0;
            r_rd_hit <= 1'b0;
        end else begin
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_rd_vld <= i_pop;
            r_rd_hit <= rd_en;
        end
    end

    assign o_res_vld = r_rd_vld;
    assign o_res     = r_rd_hit ? {r_rd_word[7:0], r_rd_word[9:8], 1'b1} : '0;

endmodule

FILE: design/tws_outbuf.sv
`timescale 1ns / 1ps

module tws_outbuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  tws_pkg::t_result     i_res,
    input  logic                 i_inflight,
    input  logic                 i_ready,
    output logic                 o_vld,
    output tws_pkg::t_result     o_res,
    output tws_pkg::t_ob_status  o_stat
);
    import tws_pkg::*;

    t_result         r_buf [OUT_DEPTH];
    logic [OUT_AW-1:0] r_wp, r_rp;
    logic [OUT_AW:0]   r_cnt, n_cnt;
    logic [OUT_AW:0]   used;
    logic              rd;

    assign o_vld        = (r_cnt != '0);
    assign o_res        = r_buf[r_rp];
    assign rd           = o_vld && i_ready;
    assign used         = r_cnt + (OUT_AW + 1)'(i_inflight);
    assign o_stat.room  = (used < (OUT_AW + 1)'(OUT_DEPTH));
    assign o_stat.full  = (r_cnt == (OUT_AW + 1)'(OUT_DEPTH));

    always_comb begin
        n_cnt = r_cnt + (OUT_AW + 1)'(i_vld) - (OUT_AW + 1)'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_buf[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_vld) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

FILE: design/two_wire_bus_sniffer_with_event_queue.sv
`timescale 1ns / 1ps

// Passive sniffer for a start/stop framed two-wire bus. Each request is a clock
// sampling edge, an IO level change or a pop; one request is taken per cycle,
// back to back, while s_axis_tready is high. Decoded START, STOP and DATA events
// go into a ring buffer in a single synchronous RAM of QUEUE_DEPTH entries that
// holds at most QUEUE_DEPTH-1 events; events arriving while it is full are
// dropped. A pop is answered at the earliest after passing the RAM read register
// and then the four-entry result buffer. s_axis_tready falls only while that
// buffer plus a read in flight would be full, i.e. under output backpressure.
// The RAM needs no clearing pass after reset.
module two_wire_bus_sniffer_with_event_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,      // sniff_enable
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // opcode[1:0], clk_level[2], io_level[3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata     // pop_valid[0], event_kind[2:1], event_data[10:3]
);
    import tws_pkg::*;

    logic       r_enable;
    logic       in_acc;
    logic [1:0] in_op;
    logic       is_pop;
    t_event_req push;
    logic       res_vld;
    t_result    res;
    t_result    out_res;
    t_q_status  q_stat;
    t_ob_status ob_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_enable <= i_cfg_data;
        end
    end

    assign in_op  = s_axis_tdata[1:0];
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign is_pop = in_acc && (in_op == OP_POP);

    tws_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (in_acc && r_enable),
        .i_op      (in_op),
        .i_clk_lvl (s_axis_tdata[2]),
        .i_io_lvl  (s_axis_tdata[3]),
        .o_push    (push)
    );

    tws_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_pop     (is_pop),
        .o_res_vld (res_vld),
        .o_res     (res),
        .o_stat    (q_stat)
    );

    tws_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (res_vld),
        .i_res      (res),
        .i_inflight (res_vld),
        .i_ready    (m_axis_tready),
        .o_vld      (m_axis_tvalid),
        .o_res      (out_res),
        .o_stat     (ob_stat)
    );

    assign s_axis_tready = ob_stat.room;
    assign m_axis_tdata  = {5'd0, out_res};

    a_not_empty_and_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue flagged empty and full at once");

    a_no_push_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enable |-> !push.vld)
        else $error("event generated while disabled");

    a_pop_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_pop |=> res_vld)
        else $error("pop request produced no read");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |-> !ob_stat.full)
        else $error("result buffer overflow");

endmodule
